/* hdl/servo_velocity_ramp_to_target_macros.svh */
// Assertion macros used by the checker file.
`ifndef SERVO_VELOCITY_RAMP_TO_TARGET_MACROS_SVH
`define SERVO_VELOCITY_RAMP_TO_TARGET_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SVR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define SVR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define SVR_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/svr_pkg.sv */
package svr_pkg;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_TARGET = 2'd1;
   localparam logic [1:0] CMD_FORCE  = 2'd2;

   localparam logic [2:0] REG_MAX_SPEED       = 3'd0;
   localparam logic [2:0] REG_ACCEL           = 3'd1;
   localparam logic [2:0] REG_TRACK_POSITION  = 3'd2;
   localparam logic [2:0] REG_DEADZONE_ENABLE = 3'd3;
   localparam logic [2:0] REG_DEADZONE        = 3'd4;
   localparam logic [2:0] REG_PULSE_STOP      = 3'd5;
   localparam logic [2:0] REG_PULSE_MIN       = 3'd6;
   localparam logic [2:0] REG_PULSE_MAX       = 3'd7;

   localparam int DT_BITS   = 16;
   localparam int CSR_BITS  = 19;

   typedef struct packed {
      logic latch;
      logic apply;
      logic mul_speed;
      logic mul_accel;
      logic integrate;
      logic capture_pos;
      logic ramp;
      logic test;
      logic div_start;
      logic snap_speed;
      logic pulse;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic track;
      logic at_goal;
      logic dt_zero;
      logic overshoot;
      logic div_done;
      logic out_free;
   } ctl_stat_type;

endpackage

/* hdl/svr_divider.sv */
module svr_divider #(
   parameter int NW = 40
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [NW-1:0]                    numer,
   input  logic [svr_pkg::DT_BITS-1:0]      denom,
   output logic [NW-1:0]                    quot,
   output logic                             done
);

   localparam int DW = svr_pkg::DT_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] quot_ff, quot_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW+1:0] shifted;
   logic [DW+1:0] trial;

   always_comb begin
      shifted = {rem_ff, quot_ff[NW-1]};
      trial   = shifted - {2'b00, den_ff};
   end

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial[DW+1]) begin
            rem_in  = shifted[DW:0];
            quot_in = {quot_ff[NW-2:0], 1'b0};
         end else begin
            rem_in  = trial[DW:0];
            quot_in = {quot_ff[NW-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

/* hdl/svr_controller.sv */
module svr_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  svr_pkg::ctl_stat_type stat,
   output svr_pkg::ctl_cmd_type  cmd
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DISPATCH = 4'd1;
   localparam logic [3:0] ST_INTEG    = 4'd2;
   localparam logic [3:0] ST_MULSTEP  = 4'd3;
   localparam logic [3:0] ST_RAMP     = 4'd4;
   localparam logic [3:0] ST_AHEAD    = 4'd5;
   localparam logic [3:0] ST_TEST     = 4'd6;
   localparam logic [3:0] ST_DIV      = 4'd7;
   localparam logic [3:0] ST_PULSE    = 4'd8;
   localparam logic [3:0] ST_DONE     = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (stat.is_tick) begin
               cmd.mul_speed = 1'b1;
               state_in      = ST_INTEG;
            end else begin
               cmd.apply = 1'b1;
               state_in  = ST_PULSE;
            end
         end
         ST_INTEG: begin
            cmd.integrate = 1'b1;
            state_in      = ST_MULSTEP;
         end
         ST_MULSTEP: begin
            cmd.mul_accel   = 1'b1;
            cmd.capture_pos = 1'b1;
            state_in        = ST_RAMP;
         end
         ST_RAMP: begin
            cmd.ramp = 1'b1;
            if (stat.track && !stat.at_goal && !stat.dt_zero) begin
               state_in = ST_AHEAD;
            end else begin
               state_in = ST_PULSE;
            end
         end
         ST_AHEAD: begin
            cmd.mul_speed = 1'b1;
            state_in      = ST_TEST;
         end
         ST_TEST: begin
            cmd.test = 1'b1;
            if (stat.overshoot) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_PULSE;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               cmd.snap_speed = 1'b1;
               state_in       = ST_PULSE;
            end
         end
         ST_PULSE: begin
            cmd.pulse = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/svr_datapath.sv */
module svr_datapath #(
   parameter int FRACTION_BITS = 8,
   parameter int POSITION_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [1:0]                     req_cmd,
   input  logic [15:0]                    req_dt,
   input  logic signed [15:0]             req_value,
   input  logic                           csr_we,
   input  logic [2:0]                     csr_index,
   input  logic [svr_pkg::CSR_BITS-1:0]   csr_data,
   input  svr_pkg::ctl_cmd_type           cmd,
   output svr_pkg::ctl_stat_type          stat,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [47:0]                    rsp_tdata
);

   localparam int F    = FRACTION_BITS;
   localparam int P    = POSITION_BITS;
   localparam int PW   = (P > 16) ? P : 16;
   localparam int AW   = PW + F;
   localparam int NW   = PW + F + 16;
   localparam int CW   = (((NW + 1) > 48) ? (NW + 1) : 48) + 1;
   localparam int SUMW = ((AW > 32) ? AW : 32) + 1;
   localparam int PLW  = 36;

   localparam logic signed [SUMW-1:0] ACC_HI = SUMW'((64'sd1 <<< (P - 1 + F)) - 64'sd1);
   localparam logic signed [SUMW-1:0] ACC_LO = -ACC_HI - SUMW'(1);
   localparam logic signed [PW:0]     VAL_HI = (PW + 1)'((64'sd1 <<< (P - 1)) - 64'sd1);
   localparam logic signed [PW:0]     VAL_LO = -VAL_HI - (PW + 1)'(1);

   // Configuration registers.
   logic signed [18:0] max_speed_ff;
   logic [17:0]        accel_ff;
   logic               track_ff, dz_en_ff;
   logic [9:0]         deadzone_ff;
   logic [11:0]        pulse_stop_ff, pulse_min_ff, pulse_max_ff;

   // Item and state registers.
   logic [1:0]            cmd_ff;
   logic [15:0]           dt_ff;
   logic signed [15:0]    val_ff;
   logic signed [AW-1:0]  accum_ff, accum_in;
   logic signed [31:0]    speed_ff, speed_in;
   logic signed [15:0]    target_ff, target_in;
   logic signed [47:0]    prod_ff;
   logic signed [PW-1:0]  pos_ff, pos_in;
   logic                  dir_pos_ff, dir_pos_in, dir_neg_ff, dir_neg_in;
   logic                  snap_ff, snap_in;
   logic                  div_neg_ff, div_neg_in;
   logic [11:0]           pulse_ff, pulse_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [47:0]           rsp_data_ff, rsp_data_in;

   // Shared multiplier.
   logic signed [32:0]    mul_a;
   logic signed [16:0]    mul_b;
   logic signed [49:0]    mul_p;

   logic signed [AW-1:0]  acc_rnd;
   logic signed [PW-1:0]  pos_now;
   logic signed [PW:0]    tgt_ext;
   logic signed [SUMW-1:0] acc_sum;
   logic signed [19:0]    goal;
   logic signed [33:0]    sp_up, sp_dn, sp_ext, goal_ext;
   logic signed [PW:0]    diff;
   logic [PW:0]           diff_mag;
   logic signed [CW-1:0]  dist_scaled, prod_ext;
   logic                  overshoot;
   logic [NW-1:0]         div_num, div_q;
   logic                  div_done;
   logic signed [31:0]    snap_speed;
   logic [32:0]           speed_mag;
   logic signed [PLW-1:0] pulse_wide, pulse_floor;
   logic signed [PLW-1:0] pmin_ext, pmax_ext;
   logic signed [PW:0]    val_ext, val_clamped;
   logic signed [PW:0]    dist_now;

   always_comb begin
      mul_a = cmd.mul_accel ? $signed({15'd0, accel_ff}) : 33'(speed_ff);
      mul_b = $signed({1'b0, dt_ff});
      mul_p = mul_a * mul_b;
   end

   // Whole position, truncated toward zero.
   always_comb begin
      acc_rnd = accum_ff + (accum_ff[AW-1] ? AW'((64'd1 << F) - 64'd1) : AW'(0));
      pos_now = $signed(acc_rnd[AW-1:F]);
      tgt_ext = (PW + 1)'(target_ff);
      acc_sum = SUMW'(accum_ff) + SUMW'($signed(prod_ff[47:16]));
   end

   always_comb begin
      goal     = dir_pos_ff ? 20'(max_speed_ff) :
                 (dir_neg_ff ? -20'(max_speed_ff) : 20'sd0);
      sp_ext   = 34'(speed_ff);
      goal_ext = 34'(goal);
      sp_up    = sp_ext + $signed({16'd0, prod_ff[33:16]});
      sp_dn    = sp_ext - $signed({16'd0, prod_ff[33:16]});
   end

   always_comb begin
      diff        = tgt_ext - (PW + 1)'(pos_ff);
      diff_mag    = diff[PW] ? (PW + 1)'(-diff) : diff;
      dist_scaled = CW'(diff) <<< (F + 16);
      prod_ext    = CW'(prod_ff);
      overshoot   = dir_pos_ff ? (prod_ext > dist_scaled) : (prod_ext < dist_scaled);
      div_num     = {diff_mag[PW-1:0], (F + 16)'(0)};
   end

   svr_divider #(.NW(NW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (div_num),
      .denom (dt_ff),
      .quot  (div_q),
      .done  (div_done)
   );

   always_comb begin
      if (div_neg_ff) begin
         snap_speed = (div_q > NW'(64'h8000_0000)) ? 32'sh8000_0000 : -$signed(div_q[31:0]);
      end else begin
         snap_speed = (div_q > NW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(div_q[31:0]);
      end
   end

   always_comb begin
      speed_mag   = speed_ff[31] ? 33'(-(33'(speed_ff))) : 33'(speed_ff);
      pulse_wide  = (PLW'($signed({1'b0, pulse_stop_ff})) <<< (F + 1)) +
                    PLW'(3) * PLW'(speed_ff);
      pulse_floor = pulse_wide >>> (F + 1);
      pmin_ext    = PLW'($signed({1'b0, pulse_min_ff}));
      pmax_ext    = PLW'($signed({1'b0, pulse_max_ff}));
      val_ext     = (PW + 1)'(val_ff);
      if (val_ext > VAL_HI) begin
         val_clamped = VAL_HI;
      end else if (val_ext < VAL_LO) begin
         val_clamped = VAL_LO;
      end else begin
         val_clamped = val_ext;
      end
      dist_now = tgt_ext - (PW + 1)'(pos_now);
   end

   always_comb begin
      accum_in     = accum_ff;
      speed_in     = speed_ff;
      target_in    = target_ff;
      pos_in       = pos_ff;
      dir_pos_in   = dir_pos_ff;
      dir_neg_in   = dir_neg_ff;
      snap_in      = snap_ff;
      div_neg_in   = div_neg_ff;
      pulse_in     = pulse_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (cmd.latch) begin
         snap_in = 1'b0;
      end
      if (cmd.apply) begin
         if (cmd_ff == svr_pkg::CMD_TARGET) begin
            target_in = val_ff;
         end else if (cmd_ff == svr_pkg::CMD_FORCE) begin
            accum_in = {val_clamped[PW-1:0], F'(0)};
         end
      end
      if (cmd.integrate && track_ff) begin
         priority if (acc_sum > ACC_HI) begin
            accum_in = AW'(ACC_HI);
         end else if (acc_sum < ACC_LO) begin
            accum_in = AW'(ACC_LO);
         end else begin
            accum_in = AW'(acc_sum);
         end
      end
      if (cmd.capture_pos) begin
         pos_in     = pos_now;
         dir_pos_in = (PW + 1)'(pos_now) < tgt_ext;
         dir_neg_in = (PW + 1)'(pos_now) > tgt_ext;
      end
      if (cmd.ramp) begin
         if (track_ff && !dir_pos_ff && !dir_neg_ff) begin
            speed_in = '0;
         end else if (sp_ext < goal_ext) begin
            speed_in = (sp_up > goal_ext) ? 32'(goal) : 32'(sp_up);
         end else if (sp_ext > goal_ext) begin
            speed_in = (sp_dn < goal_ext) ? 32'(goal) : 32'(sp_dn);
         end
      end
      if (cmd.test && overshoot) begin
         accum_in   = AW'($signed({target_ff, F'(0)}));
         pos_in     = PW'(target_ff);
         snap_in    = 1'b1;
         div_neg_in = diff[PW];
      end
      if (cmd.snap_speed) begin
         speed_in = snap_speed;
      end
      if (cmd.pulse) begin
         priority if (dz_en_ff && speed_mag < 33'({deadzone_ff, F'(0)})) begin
            if ({1'b0, pulse_stop_ff} < {1'b0, pulse_min_ff}) begin
               pulse_in = pulse_min_ff;
            end else if (pulse_stop_ff > pulse_max_ff) begin
               pulse_in = pulse_max_ff;
            end else begin
               pulse_in = pulse_stop_ff;
            end
         end else if (pulse_floor < pmin_ext) begin
            pulse_in = pulse_min_ff;
         end else if (pulse_floor > pmax_ext) begin
            pulse_in = pulse_max_ff;
         end else begin
            pulse_in = pulse_floor[11:0];
         end
         // A snap lands exactly on the target, so the speed stops afterwards.
         if (snap_ff) begin
            speed_in = '0;
         end
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, (tgt_ext == (PW + 1)'(pos_now)), dist_now[16:0],
                         pos_now[15:0], pulse_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff  <= 19'sd25600;
         accel_ff      <= 18'd2560;
         track_ff      <= 1'b1;
         dz_en_ff      <= 1'b0;
         deadzone_ff   <= 10'd20;
         pulse_stop_ff <= 12'd1500;
         pulse_min_ff  <= 12'd1000;
         pulse_max_ff  <= 12'd2000;
         accum_ff      <= '0;
         speed_ff      <= '0;
         target_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         snap_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               svr_pkg::REG_MAX_SPEED:       max_speed_ff  <= $signed(csr_data[18:0]);
               svr_pkg::REG_ACCEL:           accel_ff      <= csr_data[17:0];
               svr_pkg::REG_TRACK_POSITION:  track_ff      <= csr_data[0];
               svr_pkg::REG_DEADZONE_ENABLE: dz_en_ff      <= csr_data[0];
               svr_pkg::REG_DEADZONE:        deadzone_ff   <= csr_data[9:0];
               svr_pkg::REG_PULSE_STOP:      pulse_stop_ff <= csr_data[11:0];
               svr_pkg::REG_PULSE_MIN:       pulse_min_ff  <= csr_data[11:0];
               svr_pkg::REG_PULSE_MAX:       pulse_max_ff  <= csr_data[11:0];
               default: begin
               end
            endcase
         end
         accum_ff     <= accum_in;
         speed_ff     <= speed_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
         snap_ff      <= snap_in;
      end
      if (cmd.latch) begin
         cmd_ff <= req_cmd;
         dt_ff  <= req_dt;
         val_ff <= req_value;
      end
      if (cmd.mul_speed || cmd.mul_accel) begin
         prod_ff <= mul_p[47:0];
      end
      pos_ff      <= pos_in;
      dir_pos_ff  <= dir_pos_in;
      dir_neg_ff  <= dir_neg_in;
      div_neg_ff  <= div_neg_in;
      pulse_ff    <= pulse_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      stat.is_tick   = (cmd_ff == svr_pkg::CMD_TICK);
      stat.track     = track_ff;
      stat.at_goal   = !dir_pos_ff && !dir_neg_ff;
      stat.dt_zero   = (dt_ff == '0);
      stat.overshoot = overshoot;
      stat.div_done  = div_done;
      stat.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hdl/servo_velocity_ramp_to_target.sv */
// Sequence: a set-target or force-position word goes through the dispatch, pulse and done
// states; a tick also integrates and ramps the speed, then may look ahead and test for an
// overshoot, and when it snaps to the target it waits on the bit-serial divider.
// Throughput: one word at a time, so the next word is taken in the cycle after the answer
// is registered; a waiting answer does not hold off the next word.
// Reset (synchronous, active high) restores register defaults and zeroes position,
// speed and target.
module servo_velocity_ramp_to_target #(
   parameter int FRACTION_BITS = 8,
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // delta_time[15:0], value[31:16]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // pulse_width[11:0], position[27:12],
                                    // distance_to_go[44:28], at_target[45], zero[47:46]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [18:0] csr_data
);

   svr_pkg::ctl_cmd_type  cmd;
   svr_pkg::ctl_stat_type stat;

   assign csr_ready = 1'b1;

   svr_controller u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   svr_datapath #(
      .FRACTION_BITS (FRACTION_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_cmd    (req_tuser),
      .req_dt     (req_tdata[15:0]),
      .req_value  ($signed(req_tdata[31:16])),
      .csr_we     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* hdl/svr_checker.sv */
`include "servo_velocity_ramp_to_target_macros.svh"

module svr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // A stalled answer stays put.
   `SVR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "answer dropped or changed while stalled")

   // After reset no answer is pending.
   `SVR_ASSERT_ALWAYS(a_reset_clear, clock, reset, !rsp_tvalid, "answer pending after reset")

   // One word at a time: the block is busy right after taking one.
   `SVR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "second word taken while busy")

   // The pad bits of an answer are always zero.
   `SVR_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[47:46] == 2'b00, "answer pad bits set")

endmodule

bind servo_velocity_ramp_to_target svr_checker u_chk (.*);

/* tb/servo_velocity_ramp_to_target_tb.sv */
module servo_velocity_ramp_to_target_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam longint FRAC = 8;
   localparam longint HALF_POS = 32768;

   class servo_scoreboard;
      longint max_speed, accel, deadzone, pulse_stop, pulse_min, pulse_max;
      bit track_position, deadzone_enable;
      longint accum, speed, target;
      logic [47:0] expected_words[$];
      int errors;

      function void restore();
         max_speed = 25600; accel = 2560; track_position = 1; deadzone_enable = 0;
         deadzone = 20; pulse_stop = 1500; pulse_min = 1000; pulse_max = 2000;
         accum = 0; speed = 0; target = 0; errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [18:0] data);
         case (idx)
            svr_pkg::REG_MAX_SPEED:       max_speed = longint'(signed'(data));
            svr_pkg::REG_ACCEL:           accel = longint'(data[17:0]);
            svr_pkg::REG_TRACK_POSITION:  track_position = data[0];
            svr_pkg::REG_DEADZONE_ENABLE: deadzone_enable = data[0];
            svr_pkg::REG_DEADZONE:        deadzone = longint'(data[9:0]);
            svr_pkg::REG_PULSE_STOP:      pulse_stop = longint'(data[11:0]);
            svr_pkg::REG_PULSE_MIN:       pulse_min = longint'(data[11:0]);
            svr_pkg::REG_PULSE_MAX:       pulse_max = longint'(data[11:0]);
            default: ;
         endcase
      endfunction

      function longint whole_pos();
         return accum >= 0 ? accum >>> FRAC : -((-accum) >>> FRAC);
      endfunction

      function int heading(longint pos);
         return (target > pos) - (target < pos);
      endfunction

      function longint speed_to_pulse();
         longint mag, p;
         mag = speed < 0 ? -speed : speed;
         if (deadzone_enable && mag < (deadzone << FRAC))
            p = pulse_stop;
         else
            p = (pulse_stop * 512 + 3 * speed) >>> (FRAC + 1);
         if (p < pulse_min) return pulse_min;
         if (p > pulse_max) return pulse_max;
         return p;
      endfunction

      function longint advance(longint dt);
         longint lim, pos, goal, step, ahead, scale, pulse;
         int dir;
         lim = HALF_POS << FRAC;
         scale = longint'(1) << (FRAC + 16);
         if (track_position) begin
            accum = accum + ((speed * dt) >>> 16);
            if (accum < -lim) accum = -lim;
            if (accum > lim - 1) accum = lim - 1;
         end
         pos = whole_pos();
         dir = heading(pos);
         goal = max_speed * dir;
         step = (accel * dt) >>> 16;
         if (speed < goal) begin
            speed += step;
            if (speed > goal) speed = goal;
         end else if (speed > goal) begin
            speed -= step;
            if (speed < goal) speed = goal;
         end
         if (track_position) begin
            if (pos == target) begin
               speed = 0;
            end else if (dt != 0) begin
               ahead = pos * scale + speed * dt;
               // Landing past the target this tick: snap there instead.
               if (dir * ahead > dir * (target * scale)) begin
                  speed = ((target - pos) * scale) / dt;
                  if (speed > 64'sd2147483647) speed = 64'sd2147483647;
                  if (speed < -64'sd2147483648) speed = -64'sd2147483648;
                  accum = target << FRAC;
                  pos = target;
               end
            end
         end
         pulse = speed_to_pulse();
         if (track_position && pos == target && dir != heading(pos))
            speed = 0;
         return pulse;
      endfunction

      function void note(logic [1:0] cmd, logic [15:0] dt, logic [15:0] val);
         longint pulse, pos, v;
         v = longint'(signed'(val));
         if (cmd == svr_pkg::CMD_TICK) begin
            pulse = advance(longint'(dt));
         end else begin
            if (cmd == svr_pkg::CMD_TARGET) target = v;
            else if (cmd == svr_pkg::CMD_FORCE) accum = v << FRAC;
            pulse = speed_to_pulse();
         end
         pos = whole_pos();
         expected_words.push_back({2'b00, pos == target, 17'(target - pos), 16'(pos),
                                   12'(pulse)});
      endfunction

      function void check(logic [47:0] got);
         logic [47:0] want;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word %h", $time, got);
            errors++;
            return;
         end
         want = expected_words.pop_front();
         if (got[11:0] !== want[11:0]) begin
            $display("%0t: pulse_width expected %0d actual %0d", $time, want[11:0], got[11:0]);
            errors++;
         end
         if (got[27:12] !== want[27:12]) begin
            $display("%0t: position expected %0d actual %0d", $time,
                     $signed(want[27:12]), $signed(got[27:12]));
            errors++;
         end
         if (got[44:28] !== want[44:28]) begin
            $display("%0t: distance_to_go expected %0d actual %0d", $time,
                     $signed(want[44:28]), $signed(got[44:28]));
            errors++;
         end
         if (got[47:45] !== want[47:45]) begin
            $display("%0t: at_target/pad expected %b actual %b", $time,
                     want[47:45], got[47:45]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = '0;
   logic [18:0] csr_data = '0;

   int tx_idle = 12, rx_idle = 46;
   int random_sent = 0;
   servo_scoreboard servo_model;

   servo_velocity_ramp_to_target uut (.*);

   always #5 clock = ~clock;

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= rx_idle);

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) servo_model.check(rsp_tdata);

   task automatic send_word(logic [1:0] cmd, logic [15:0] dt, logic [15:0] val);
      while ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= {val, dt};
      do @(posedge clock); while (!req_tready);
      servo_model.note(cmd, dt, val);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (servo_model.expected_words.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [18:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      servo_model.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic random_words(int n);
      int pick;
      logic [15:0] val;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            val = $urandom_range(3) == 0 ? 16'($urandom) :
                  16'(servo_model.whole_pos() + $signed($urandom_range(400)) - 200);
            send_word(svr_pkg::CMD_TARGET, 16'($urandom), val);
         end else if (pick < 12) begin
            send_word(svr_pkg::CMD_FORCE, 16'($urandom),
                      $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(60)));
         end else if (pick < 14) begin
            send_word(CMD_UNUSED, 16'($urandom), 16'($urandom));
         end else begin
            send_word(svr_pkg::CMD_TICK, $urandom_range(3) == 0 ? 16'($urandom) :
                      16'($urandom_range(8000)), 16'($urandom));
         end
         random_sent++;
         // Swap the idle shares partway through, then stop idling altogether.
         if (random_sent == 140) begin
            tx_idle = 46;
            rx_idle = 12;
         end else if (random_sent == 280) begin
            tx_idle = 0;
            rx_idle = 0;
         end
      end
   endtask

   initial begin
      servo_model = new();
      servo_model.restore();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: extremes, each command, zero tick, snaps and saturation.
      send_word(svr_pkg::CMD_TICK, 16'd0, 16'd0);
      send_word(svr_pkg::CMD_TARGET, 16'd0, 16'd5);
      repeat (6) send_word(svr_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF);
      send_word(svr_pkg::CMD_TICK, 16'd0, 16'd0);
      send_word(svr_pkg::CMD_TARGET, 16'd0, 16'h8000);
      send_word(svr_pkg::CMD_FORCE, 16'hFFFF, 16'h7FFF);
      send_word(svr_pkg::CMD_TICK, 16'hFFFF, 16'd0);
      send_word(svr_pkg::CMD_FORCE, 16'd0, 16'h8000);
      send_word(svr_pkg::CMD_TARGET, 16'd0, 16'h7FFF);
      send_word(svr_pkg::CMD_TICK, 16'h8000, 16'd0);
      send_word(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
      send_word(svr_pkg::CMD_FORCE, 16'd0, 16'd0);
      send_word(svr_pkg::CMD_TARGET, 16'd0, 16'hFFFE);
      repeat (5) send_word(svr_pkg::CMD_TICK, 16'hFFFF, 16'd0);
      drain();

      random_words(100);
      drain();
      write_reg(svr_pkg::REG_MAX_SPEED, 19'h40000);
      write_reg(svr_pkg::REG_ACCEL, 19'h3FFFF);
      write_reg(svr_pkg::REG_DEADZONE_ENABLE, 19'd1);
      write_reg(svr_pkg::REG_DEADZONE, 19'd1023);
      write_reg(svr_pkg::REG_PULSE_STOP, 19'd4095);
      write_reg(svr_pkg::REG_PULSE_MIN, 19'd0);
      write_reg(svr_pkg::REG_PULSE_MAX, 19'd4095);
      random_words(100);
      drain();
      write_reg(svr_pkg::REG_TRACK_POSITION, 19'd0);
      write_reg(svr_pkg::REG_MAX_SPEED, 19'h3FFFF);
      write_reg(svr_pkg::REG_ACCEL, 19'd0);
      write_reg(svr_pkg::REG_DEADZONE, 19'd0);
      write_reg(svr_pkg::REG_PULSE_STOP, 19'd0);
      write_reg(svr_pkg::REG_PULSE_MIN, 19'd3000);
      write_reg(svr_pkg::REG_PULSE_MAX, 19'd100);
      random_words(50);
      drain();
      write_reg(svr_pkg::REG_ACCEL, 19'd60000);
      random_words(50);
      drain();
      write_reg(svr_pkg::REG_TRACK_POSITION, 19'd1);
      write_reg(svr_pkg::REG_DEADZONE_ENABLE, 19'd0);
      write_reg(svr_pkg::REG_MAX_SPEED, 19'($urandom_range(60000)));
      write_reg(svr_pkg::REG_ACCEL, 19'($urandom_range(20000)));
      write_reg(svr_pkg::REG_DEADZONE, 19'($urandom_range(1023)));
      write_reg(svr_pkg::REG_PULSE_STOP, 19'd1500);
      write_reg(svr_pkg::REG_PULSE_MIN, 19'd900);
      write_reg(svr_pkg::REG_PULSE_MAX, 19'd2100);
      random_words(110);

      req_tvalid <= 0;
      while (servo_model.expected_words.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (servo_model.errors == 0)
         $display("PASS servo_velocity_ramp_to_target");
      else
         $display("FAIL servo_velocity_ramp_to_target");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL servo_velocity_ramp_to_target");
      $finish;
   end
endmodule
